FILE: design/c2c_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the arctangent table for the cylindrical converter.
package c2c_pkg;

	localparam int COORD_W      = 24;
	localparam int MIN_RADIUS_W = 10;
	localparam int SUM_W        = 2 * COORD_W;
	localparam int ROOT_W       = COORD_W;
	localparam int SQRT_STAGES  = COORD_W;
	localparam int GUARD_BITS   = 6;
	localparam int CORDIC_W     = 33;
	localparam int ACC_W        = 32;
	localparam int TABLE_LEN    = 24;

	// square, sum, then one register per root bit
	localparam int ALIGN_DEPTH  = 2 + SQRT_STAGES;

	localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic signed [CORDIC_W-1:0] cord_t;
	typedef logic [ACC_W-1:0]           angle_t;

	// arctan(2^-i) in units of one turn / 2^32
	localparam angle_t ATAN_TURNS [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

endpackage

FILE: design/c2c_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
module c2c_sqrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [c2c_pkg::SUM_W-1:0]        sum_in,
	output logic [c2c_pkg::ROOT_W-1:0]       root_out,
	output logic [c2c_pkg::ROOT_W:0]         rem_out
);

	localparam int SW = c2c_pkg::SUM_W;
	localparam int NS = c2c_pkg::SQRT_STAGES;

	logic [SW-1:0] rem_s  [1:NS];
	logic [SW-1:0] root_s [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_bit
		localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);

		logic [SW-1:0] rem_c;
		logic [SW-1:0] root_c;
		logic [SW:0]   trial;

		if (k == 0) begin : g_first
			assign rem_c  = sum_in;
			assign root_c = '0;
		end else begin : g_next
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
		end

		assign trial = {1'b0, root_c} + {1'b0, BIT};

		// take the bit when the remainder covers the trial value
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_c} >= trial) begin
					rem_s[k+1]  <= rem_c - trial[SW-1:0];
					root_s[k+1] <= (root_c >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= rem_c;
					root_s[k+1] <= root_c >> 1;
				end
			end
		end
	end

	assign root_out = root_s[NS][c2c_pkg::ROOT_W-1:0];
	assign rem_out  = rem_s[NS][c2c_pkg::ROOT_W:0];

endmodule

FILE: design/c2c_cordic.sv
`timescale 1ns / 1ps
// Unrolled CORDIC vectoring pipeline that accumulates the azimuth in binary turns.
module c2c_cordic #(
	parameter int STAGES = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  c2c_pkg::coord_t         x_in,
	input  c2c_pkg::coord_t         y_in,
	output c2c_pkg::angle_t         acc_out
);

	localparam int CW  = c2c_pkg::CORDIC_W;
	localparam int DLY = c2c_pkg::ALIGN_DEPTH - 1 - STAGES;

	c2c_pkg::cord_t  cx_s  [0:STAGES];
	c2c_pkg::cord_t  cy_s  [0:STAGES];
	c2c_pkg::angle_t acc_s [0:STAGES];
	c2c_pkg::angle_t acc_dly_s [DLY];

	c2c_pkg::cord_t x_ext;
	c2c_pkg::cord_t y_ext;
	logic           x_neg;

	assign x_ext = {{(CW - c2c_pkg::COORD_W){x_in[c2c_pkg::COORD_W-1]}}, x_in};
	assign y_ext = {{(CW - c2c_pkg::COORD_W){y_in[c2c_pkg::COORD_W-1]}}, y_in};
	assign x_neg = x_in[c2c_pkg::COORD_W-1];

	// half-turn pre-rotation puts the vector in the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_neg) begin
				cx_s[0]  <= (-x_ext) <<< c2c_pkg::GUARD_BITS;
				cy_s[0]  <= (-y_ext) <<< c2c_pkg::GUARD_BITS;
				acc_s[0] <= c2c_pkg::HALF_TURN;
			end else begin
				cx_s[0]  <= x_ext <<< c2c_pkg::GUARD_BITS;
				cy_s[0]  <= y_ext <<< c2c_pkg::GUARD_BITS;
				acc_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][CW-1]) begin
					cx_s[i+1]  <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1]  <= cy_s[i] - (cx_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] + c2c_pkg::ATAN_TURNS[i];
				end else begin
					cx_s[i+1]  <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1]  <= cy_s[i] + (cx_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] - c2c_pkg::ATAN_TURNS[i];
				end
			end
		end
	end

	// delay the angle to line up with the square-root path
	for (genvar d = 0; d < DLY; d++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				if (d == 0) begin
					acc_dly_s[d] <= acc_s[STAGES];
				end else begin
					acc_dly_s[d] <= acc_dly_s[(d == 0) ? 0 : d - 1];
				end
			end
		end
	end

	assign acc_out = acc_dly_s[DLY-1];

endmodule

FILE: design/cartesian_to_cylindrical.sv
`timescale 1ns / 1ps
// Top level: streaming Cartesian to cylindrical coordinate converter.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one point x_coord, y_coord, z_coord
//   per transfer, signed fixed point. Output channel (out_valid/out_ready) returns
//   one result per point, in order: radius = round(sqrt(x*x + y*y)), azimuth as
//   an unsigned binary angle counterclockwise from +x, and height_out = z.
//   When the rounded radius is at or below min_radius the azimuth reads 0.
//   min_radius is loaded through the cfg_valid/cfg_ready/cfg_data channel, which
//   always takes a transfer; write it only while no point is in flight.
// Pipeline and throughput:
//   From input transfer to out_valid a point passes the square-root pipeline
//   (a squaring stage and a summing stage, then one register per root bit, then a
//   rounding stage). One point per cycle is taken while the output is drained.
// Stall:
//   When out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is dropped or repeated.
// Reset:
//   arst_n clears all stage valid bits and sets min_radius to 0.
module cartesian_to_cylindrical #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [c2c_pkg::MIN_RADIUS_W-1:0]     cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [c2c_pkg::COORD_W-1:0]   x_coord,
	input  logic signed [c2c_pkg::COORD_W-1:0]   y_coord,
	input  logic signed [c2c_pkg::COORD_W-1:0]   z_coord,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [c2c_pkg::COORD_W-1:0]          radius,
	output logic [ANGLE_BITS-1:0]                azimuth,
	output logic signed [c2c_pkg::COORD_W-1:0]   height_out
);

	localparam int CW   = c2c_pkg::COORD_W;
	localparam int SW   = c2c_pkg::SUM_W;
	localparam int AW   = c2c_pkg::ACC_W;
	localparam int AD   = c2c_pkg::ALIGN_DEPTH;
	localparam int LAT  = AD + 1;
	// half of one output angle LSB, in accumulator units
	localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (AW - 1 - ANGLE_BITS);

	logic en;

	// one valid bit per stage, bit k for stage k
	logic [LAT:1] vld_s;

	logic [c2c_pkg::MIN_RADIUS_W-1:0] min_radius_q;

	logic signed [SW-1:0] sqx_c;
	logic signed [SW-1:0] sqy_c;
	logic [SW-1:0]        sqx_s1;
	logic [SW-1:0]        sqy_s1;
	logic [SW-1:0]        sum_s2;

	c2c_pkg::coord_t z_s [1:AD];

	logic [c2c_pkg::ROOT_W-1:0] root_s26;
	logic [c2c_pkg::ROOT_W:0]   rem_s26;
	c2c_pkg::angle_t            acc_s26;

	logic [CW-1:0]         rad_rnd;
	logic [AW-1:0]         az_sum;
	logic [ANGLE_BITS-1:0] az_rnd;
	logic                  az_keep;

	logic [CW-1:0]         radius_s27;
	logic [ANGLE_BITS-1:0] azimuth_s27;
	c2c_pkg::coord_t       height_s27;

	// advance everything unless a finished result is waiting and out_ready is low
	assign en        = !vld_s[LAT] || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q <= '0;
		end else if (cfg_valid) begin
			min_radius_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	// squares and sum of squares; sign-extended 24 by 24 bit products
	assign sqx_c = SW'(x_coord) * SW'(x_coord);
	assign sqy_c = SW'(y_coord) * SW'(y_coord);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= sqx_c;
			sqy_s1 <= sqy_c;
			sum_s2 <= sqx_s1 + sqy_s1;
		end
	end

	// carry z alongside the arithmetic
	for (genvar k = 1; k <= AD; k++) begin : g_z
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 1) begin
					z_s[k] <= z_coord;
				end else begin
					z_s[k] <= z_s[(k == 1) ? 1 : k - 1];
				end
			end
		end
	end

	c2c_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.sum_in   (sum_s2),
		.root_out (root_s26),
		.rem_out  (rem_s26)
	);

	c2c_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.en      (en),
		.x_in    (x_coord),
		.y_in    (y_coord),
		.acc_out (acc_s26)
	);

	// round the root up when the remainder exceeds it
	assign rad_rnd = root_s26 + CW'(rem_s26 > {1'b0, root_s26});
	assign az_sum  = acc_s26 + ROUND_HALF;
	assign az_rnd  = az_sum[AW-1 -: ANGLE_BITS];
	assign az_keep = rad_rnd > CW'(min_radius_q);

	always_ff @(posedge clk) begin
		if (en) begin
			radius_s27  <= rad_rnd;
			azimuth_s27 <= az_keep ? az_rnd : '0;
			height_s27  <= z_s[AD];
		end
	end

	assign out_valid  = vld_s[LAT];
	assign radius     = radius_s27;
	assign azimuth    = azimuth_s27;
	assign height_out = height_s27;

endmodule

FILE: design/c2c_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the cylindrical converter, bound to the top level.
module c2c_checker #(
	parameter int ANGLE_BITS = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [c2c_pkg::COORD_W-1:0]        radius,
	input logic [ANGLE_BITS-1:0]              azimuth,
	input logic [c2c_pkg::COORD_W-1:0]        height_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(radius) && $stable(azimuth)
			&& $stable(height_out))
		else $error("stalled result changed");

	// a stall at the output freezes the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");

	// an empty output never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a zero radius never carries an angle
	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && radius == '0 |-> azimuth == '0)
		else $error("nonzero azimuth at zero radius");

endmodule

bind cartesian_to_cylindrical c2c_checker #(.ANGLE_BITS(ANGLE_BITS)) u_c2c_checker (.*);

FILE: tb/tb_cartesian_to_cylindrical.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming Cartesian to cylindrical converter.
module tb_cartesian_to_cylindrical;

	localparam int AZ_BITS       = 16;
	localparam int AZ_STAGES     = 16;
	localparam int GUARD_SHIFT   = 6;
	localparam int ATAN_LEN      = 24;
	// Give the pipeline margin to empty before touching min_radius.
	localparam int SETTLE_CYCLES = 40;
	localparam int LIMIT_CYCLES  = 250000;
	localparam int PHASE_POINTS  = 460;
	localparam int MAX_REPORTS   = 30;

	localparam c2c_pkg::coord_t COORD_MAX = 24'h7FFFFF;
	localparam c2c_pkg::coord_t COORD_MIN = 24'h800000;
	localparam bit [31:0] HALF_TURN_UNITS = 32'h8000_0000;

	// arctan(2^-i) in binary-angle units of one turn / 2^32
	localparam bit [31:0] ATAN_TURN [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Scoreboard: predicts radius/azimuth/height per accepted point, checks in order.
	class cyl_scoreboard;
		typedef struct {
			logic [23:0]        radius;
			logic [AZ_BITS-1:0] azimuth;
			logic [23:0]        height;
		} cyl_t;

		bit [9:0] min_radius;
		cyl_t     cyl_due[$];
		int       mismatches;
		int       points_noted;
		int       results_checked;

		function new();
			min_radius = '0;
			mismatches = 0;
			points_noted = 0;
			results_checked = 0;
		endfunction

		function void set_min_radius(bit [9:0] value);
			min_radius = value;
		endfunction

		function int pending();
			return cyl_due.size();
		endfunction

		function longint unsigned int_sqrt(longint unsigned value);
			longint unsigned root;
			longint unsigned probe;
			root = 0;
			probe = 64'd1 << 62;
			while (probe > value)
				probe = probe >> 2;
			while (probe != 0) begin
				if (value >= root + probe) begin
					value = value - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			return root;
		endfunction

		function cyl_t cylindrical_of(c2c_pkg::coord_t x, c2c_pkg::coord_t y,
				c2c_pkg::coord_t z);
			longint sx, sy, cx, cy, dx, dy;
			longint unsigned sum, root;
			bit [31:0] turns;
			bit [32:0] rounded;
			cyl_t res;
			sx = 64'(x);
			sy = 64'(y);
			sum = sx * sx + sy * sy;
			root = int_sqrt(sum);
			// round to nearest: bump when the remainder exceeds the root
			if (sum - root * root > root)
				root = root + 1;
			res.radius = root[23:0];
			res.azimuth = '0;
			res.height = z;
			if (root > min_radius) begin
				turns = '0;
				// fold the left half-plane over with a half-turn pre-rotation
				if (sx < 0) begin
					sx = -sx;
					sy = -sy;
					turns = HALF_TURN_UNITS;
				end
				cx = sx * (64'sd1 << GUARD_SHIFT);
				cy = sy * (64'sd1 << GUARD_SHIFT);
				for (int i = 0; i < AZ_STAGES && i < ATAN_LEN; i++) begin
					dx = cy >>> i;
					dy = cx >>> i;
					if (cy >= 0) begin
						cx = cx + dx;
						cy = cy - dy;
						turns = turns + ATAN_TURN[i];
					end else begin
						cx = cx - dx;
						cy = cy + dy;
						turns = turns - ATAN_TURN[i];
					end
				end
				// round half up, then drop the carry so a full turn wraps to 0
				rounded = {1'b0, turns} + (33'd1 << (31 - AZ_BITS));
				res.azimuth = rounded[31:32-AZ_BITS];
			end
			return res;
		endfunction

		function void note_point(c2c_pkg::coord_t x, c2c_pkg::coord_t y, c2c_pkg::coord_t z);
			cyl_due.push_back(cylindrical_of(x, y, z));
			points_noted++;
		endfunction

		function void flag(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		endfunction

		function void check_result(logic [23:0] rad, logic [AZ_BITS-1:0] az, logic [23:0] hgt);
			cyl_t want;
			if (cyl_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing expected, expected none, got %0d/%0d/%0d",
						$time, rad, az, hgt);
				return;
			end
			want = cyl_due.pop_front();
			results_checked++;
			if (rad !== want.radius)
				flag("radius", 32'(want.radius), 32'(rad));
			if (az !== want.azimuth)
				flag("azimuth", 32'(want.azimuth), 32'(az));
			if (hgt !== want.height)
				flag("height_out", 32'(want.height), 32'(hgt));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [c2c_pkg::MIN_RADIUS_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	c2c_pkg::coord_t x_coord;
	c2c_pkg::coord_t y_coord;
	c2c_pkg::coord_t z_coord;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [c2c_pkg::COORD_W-1:0] radius;
	logic [AZ_BITS-1:0] azimuth;
	c2c_pkg::coord_t height_out;

	cyl_scoreboard sb = new();

	// Flow-control mix of the current phase, in percent per cycle.
	int src_idle_pct;
	int sink_stall_pct;
	int cycle_count = 0;
	int settings_written;

	cartesian_to_cylindrical #(
		.ANGLE_BITS    (AZ_BITS),
		.CORDIC_STAGES (AZ_STAGES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.radius     (radius),
		.azimuth    (azimuth),
		.height_out (height_out)
	);

	// 12 ns clock, low half first.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: drop out_ready at random at the phase's stall rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Monitor: every output transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(radius, azimuth, height_out);
	end

	// Pick one of the corner coordinate values, or a random one.
	function automatic c2c_pkg::coord_t corner_value();
		bit [31:0] rnd;
		rnd = $urandom;
		case ($urandom_range(0, 5))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return -24'sd1;
			3: return 24'sd0;
			4: return 24'sd1;
			default: return rnd[23:0];
		endcase
	endfunction

	// Draw one random point; bias a share of them toward the interesting regions.
	function automatic void pick_point(input bit [9:0] floor_r, output c2c_pkg::coord_t x,
			output c2c_pkg::coord_t y, output c2c_pkg::coord_t z);
		bit [31:0] rx, ry, rz;
		int r;
		int k;
		rx = $urandom;
		ry = $urandom;
		rz = $urandom;
		x = rx[23:0];
		y = ry[23:0];
		z = ($urandom_range(0, 7) == 0) ? corner_value() : rz[23:0];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;	// full-range point, keep as drawn
			4: begin
				// tiny radius, lots of hits around the threshold for small settings
				x = 24'($urandom_range(0, 4095) - 2048);
				y = 24'($urandom_range(0, 4095) - 2048);
			end
			5: begin
				// radius right at, just under or just over min_radius
				r = int'(floor_r) + int'($urandom_range(0, 2)) - 1;
				if (r < 0)
					r = 0;
				k = r / 5;
				case ($urandom_range(0, 4))
					0: begin x = 24'(r);  y = '0;      end
					1: begin x = 24'(-r); y = '0;      end
					2: begin x = '0;      y = 24'(r);  end
					3: begin x = '0;      y = 24'(-r); end
					default: begin
						// 3-4-5 triangle lands exactly on radius 5k
						x = 24'(($urandom_range(0, 1) != 0) ? 3 * k : -3 * k);
						y = 24'(($urandom_range(0, 1) != 0) ? 4 * k : -4 * k);
					end
				endcase
			end
			6: begin
				// on an axis
				if ($urandom_range(0, 1) != 0)
					x = '0;
				else
					y = '0;
			end
			7: begin
				// on a diagonal, |x| == |y|
				y = ($urandom_range(0, 1) != 0) ? x : -x;
			end
			8: begin
				x = corner_value();
				y = corner_value();
			end
			default: begin
				// left half-plane near the negative x axis: the half-turn fold and
				// the sign of y decide between just under and just over pi
				if (x >= 0)
					x = -x - 24'sd1;
				y = 24'($urandom_range(0, 6) - 3);
			end
		endcase
	endfunction

	// Hold min_radius on the config channel until it transfers.
	task automatic write_min_radius(input bit [9:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_min_radius(value);
		settings_written++;
	endtask

	// Idle at the phase rate, then present the point and hold it until it transfers.
	task automatic send_point(input c2c_pkg::coord_t x, input c2c_pkg::coord_t y,
			input c2c_pkg::coord_t z);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		z_coord <= z;
		do @(posedge clk); while (!in_ready);
		sb.note_point(x, y, z);
	endtask

	// Drop valid, wait for every prediction to be matched, then let the pipe settle.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		// Directed points, run with min_radius at its top value of 1023.
		c2c_pkg::coord_t dir_x [22];
		c2c_pkg::coord_t dir_y [22];
		c2c_pkg::coord_t px, py, pz;
		bit [31:0] rnd;
		bit [9:0] floor_r;

		dir_x = '{
			24'sd0, 24'sd1023, 24'sd1024, 24'sd0, -24'sd1023, -24'sd1024,
			24'sd723, 24'sd724, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, 24'sd0, COORD_MAX, 24'sd0, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, -24'sd1000000, 24'sd0
		};
		dir_y = '{
			24'sd0, 24'sd0, 24'sd0, -24'sd1024, 24'sd0, 24'sd0,
			24'sd724, 24'sd724, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			24'sd0, COORD_MIN, 24'sd0, COORD_MAX, -24'sd1, 24'sd1,
			24'sd1, -24'sd1, 24'sd0, -24'sd1000000
		};

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		settings_written = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, axes, half-turn fold, threshold on both sides.
		write_min_radius(10'd1023);
		for (int i = 0; i < 22; i++) begin
			rnd = $urandom;
			case (i % 5)
				0: pz = COORD_MIN;
				1: pz = COORD_MAX;
				2: pz = 24'sd0;
				3: pz = -24'sd1;
				default: pz = rnd[23:0];
			endcase
			send_point(dir_x[i], dir_y[i], pz);
		end
		drain_pipeline();

		// Random phases, each with its own min_radius and flow-control mix.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					floor_r = 10'd0;
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					floor_r = 10'($urandom_range(1, 1022));
					src_idle_pct = 79;
					sink_stall_pct = 0;
				end
				2: begin
					floor_r = 10'd1023;
					src_idle_pct = 0;
					sink_stall_pct = 79;
				end
				default: begin
					floor_r = 10'($urandom_range(1, 1022));
					src_idle_pct = 27;
					sink_stall_pct = 27;
				end
			endcase
			write_min_radius(floor_r);
			for (int n = 0; n < PHASE_POINTS; n++) begin
				pick_point(floor_r, px, py, pz);
				send_point(px, py, pz);
			end
			drain_pipeline();
		end

		$display("Sent %0d points, checked %0d results, %0d mismatches", sb.points_noted,
			sb.results_checked, sb.mismatches);
		$display("Covered %0d min_radius settings (0 and 1023 included) and four flow mixes",
			settings_written);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
